>>> rtl/bit_event_word_merger_macros.svh
// Assertion macros for the bit event word merger checker
`ifndef BIT_EVENT_WORD_MERGER_MACROS_SVH
`define BIT_EVENT_WORD_MERGER_MACROS_SVH
`define BEWM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("bewm check failed");
`define BEWM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("bewm check failed");
`endif

>>> rtl/bewm_pkg.sv
// Package: constants, opcodes and types of the bit event word merger
package bewm_pkg;
	localparam int LINES_DEF = 32;
	localparam int EVENTS_DEF = 256;
	localparam int OP_W = 2;
	localparam int LINE_W = 5;
	localparam int TIME_W = 32;
	localparam int WORD_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_REQ   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [LINE_W-1:0] line;
		logic [TIME_W-1:0] event_time;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_UPD,
		ST_OUT,
		ST_CLR
	} st_t;
endpackage

>>> rtl/bit_event_word_merger.sv
// Top level of the bit event word merger
// Slave stream carries load, request and clear items; master stream carries
// one result item for each request item and nothing for the other kinds.
// A load stores an event time at the tail of its line (up to EVENTS per line;
// a load to a full line is dropped and sets the sticky overflow bit).
// A request scans the line heads one at a time, each in a read and a compare
// state, through the single read port of the event memory and one comparator;
// then the winning heads advance and the result waits for m_axis_tready.
// A clear sweeps the line counters one line at a time. A load is handled in idle.
// A two-entry queue sits between the input side and the scan engine, so
// items are taken while a result is still waiting to be taken.
// While the receiver stalls the result holds and the queue fills, after
// which s_axis_tready drops.
// Reset empties every line and clears overflow; event memory is not cleared.
// Opcode 3 is taken and discarded.
module bit_event_word_merger import bewm_pkg::*; #(
	parameter int LINES = LINES_DEF,
	parameter int EVENTS = EVENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // op[1:0], line[6:2], event_time[38:7]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // word[31:0], word_time[63:32], done_res[64], overflow[65]
);
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	logic [WORD_W-1:0] word;
	logic [TIME_W-1:0] wtime;
	logic done_res, overflow;

	assign in_cmd.op = op_t'(s_axis_tdata[1:0]);
	assign in_cmd.line = s_axis_tdata[6:2];
	assign in_cmd.event_time = s_axis_tdata[38:7];
	assign m_axis_tdata = {6'd0, overflow, done_res, wtime, word};

	bewm_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	bewm_back #(.LINES(LINES), .EVENTS(EVENTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(word), .out_time(wtime), .out_done(done_res), .out_ovf(overflow)
	);
endmodule

>>> rtl/bewm_front.sv
// Front end: accept items, drop unused opcodes, queue commands for the back end
module bewm_front import bewm_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic q_valid,
	input  logic q_ready,
	output cmd_t q_cmd
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	cmd_t buf_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign push = in_valid && in_ready && (in_cmd.op != OP_NONE);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_cmd = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

>>> rtl/bewm_back.sv
// Back end: event memory, per-line counters and the sequential head scan
module bewm_back import bewm_pkg::*; #(
	parameter int LINES = LINES_DEF,
	parameter int EVENTS = EVENTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  cmd_t              q_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_word,
	output logic [TIME_W-1:0] out_time,
	output logic              out_done,
	output logic              out_ovf
);
	localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int EW = $clog2(EVENTS);
	localparam int CW = EW + 1;
	localparam int SLOTS = LINES * (2 ** EW);

	logic [TIME_W-1:0] mem [SLOTS];
	logic [TIME_W-1:0] rd_q;
	logic [CW-1:0] fill_q [LINES];
	logic [CW-1:0] ridx_q [LINES];
	logic ovf_q;
	st_t st_q, st_d;
	logic [LW-1:0] idx_q;
	logic [WORD_W-1:0] word_q;
	logic [TIME_W-1:0] best_q;
	logic found_q, live_q;
	logic [LW-1:0] ln;
	logic ln_ok, full, last, live;
	logic [LW+EW-1:0] waddr, raddr;

	assign ln = q_cmd.line[LW-1:0];
	assign ln_ok = (32'(q_cmd.line) < LINES);
	assign full = (fill_q[ln] == CW'(EVENTS));
	assign waddr = {ln, fill_q[ln][EW-1:0]};
	assign raddr = {idx_q, ridx_q[idx_q][EW-1:0]};
	assign live = (ridx_q[idx_q] != fill_q[idx_q]);
	assign last = (idx_q == LW'(LINES-1));
	assign q_ready = (st_q == ST_IDLE);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (q_valid && q_cmd.op == OP_REQ) begin
					st_d = ST_RD;
				end else if (q_valid && q_cmd.op == OP_CLEAR) begin
					st_d = ST_CLR;
				end
			end
			ST_RD:  st_d = ST_CMP;
			ST_CMP: st_d = last ? ST_UPD : ST_RD;
			ST_UPD: st_d = ST_OUT;
			ST_OUT: st_d = out_ready ? ST_IDLE : ST_OUT;
			ST_CLR: st_d = last ? ST_IDLE : ST_CLR;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid = (st_q == ST_OUT);
		out_word = word_q;
		out_time = found_q ? best_q : '0;
		out_done = !found_q;
		out_ovf = ovf_q;
	end

	always_ff @(posedge clk) begin
		if (q_ready && q_valid && q_cmd.op == OP_LOAD && ln_ok && !full) begin
			mem[waddr] <= q_cmd.event_time;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			word_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			live_q <= 1'b0;
			ovf_q <= 1'b0;
			for (int i = 0; i < LINES; i++) begin
				fill_q[i] <= '0;
				ridx_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_IDLE: begin
					idx_q <= '0;
					word_q <= '0;
					found_q <= 1'b0;
					if (q_valid && q_cmd.op == OP_LOAD && ln_ok) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							fill_q[ln] <= fill_q[ln] + 1'b1;
						end
					end
				end
				ST_RD: live_q <= live;
				ST_CMP: begin
					if (live_q) begin
						if (!found_q || rd_q < best_q) begin
							best_q <= rd_q;
							word_q <= WORD_W'(1) << idx_q;
							found_q <= 1'b1;
						end else if (rd_q == best_q) begin
							word_q <= word_q | (WORD_W'(1) << idx_q);
						end
					end
					if (!last) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_UPD: begin
					for (int i = 0; i < LINES; i++) begin
						if (word_q[i]) begin
							ridx_q[i] <= ridx_q[i] + 1'b1;
						end
					end
				end
				ST_CLR: begin
					fill_q[idx_q] <= '0;
					ridx_q[idx_q] <= '0;
					idx_q <= last ? '0 : idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/bewm_checker.sv
// Port checker for the bit event word merger, bound to the top level
`include "bit_event_word_merger_macros.svh"
module bewm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);
	`BEWM_ASSERT_IMP(a_done_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[64], m_axis_tdata[63:0] == 64'd0)
	`BEWM_ASSERT_IMP(a_word_set, clk, arst_n, m_axis_tvalid && !m_axis_tdata[64], m_axis_tdata[31:0] != 32'd0)
	`BEWM_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`BEWM_ASSERT_NXT(a_ovf_sticky, clk, arst_n, m_axis_tvalid && m_axis_tdata[65], !m_axis_tvalid || m_axis_tdata[65])
endmodule

bind bit_event_word_merger bewm_checker u_bewm_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

>>> bench/bit_event_word_merger_tb.sv
`timescale 1ns / 1ps
// Self-checking bench: load/request/clear items against a local merge predictor
module bit_event_word_merger_tb;
	import bewm_pkg::*;

	localparam int N_LINES = LINES_DEF;
	localparam int DEPTH = EVENTS_DEF;
	localparam int N_RANDOM = 1160;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic        overflow;
		logic        done_res;
		logic [31:0] word_time;
		logic [31:0] word;
	} word_res_t;

	typedef struct {
		op_t         op;
		logic [4:0]  line;
		logic [31:0] t;
		bit          typed;
		word_res_t   res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;

	bit [31:0] line_times [N_LINES][DEPTH];
	int        line_fill [N_LINES];
	int        line_head [N_LINES];
	bit        ovf_sticky;
	int        line_last [N_LINES];

	word_res_t pending_words[$];
	int        fails = 0;
	int        idle_cycles = 0;
	bit        hold_off = 0;
	stim_row_t rows[$];

	bit_event_word_merger DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void merge_apply(op_t op, logic [4:0] ln, logic [31:0] t);
		word_res_t r;
		bit found;
		bit [31:0] best;
		bit [31:0] h;
		case (op)
			OP_LOAD: begin
				if (line_fill[ln] >= DEPTH) begin
					ovf_sticky = 1'b1;
				end else begin
					line_times[ln][line_fill[ln]] = t;
					line_fill[ln]++;
				end
			end
			OP_REQ: begin
				found = 0;
				best = '0;
				r = '0;
				for (int i = 0; i < N_LINES; i++) begin
					if (line_head[i] >= line_fill[i]) continue;
					h = line_times[i][line_head[i]];
					if (!found || h < best) begin
						best = h;
						r.word = 32'd1 << i;
						found = 1;
					end else if (h == best) begin
						r.word[i] = 1'b1;
					end
				end
				for (int i = 0; i < N_LINES; i++)
					if (r.word[i]) line_head[i]++;
				r.word_time = found ? best : 32'd0;
				r.done_res = !found;
				r.overflow = ovf_sticky;
				pending_words.push_back(r);
			end
			OP_CLEAR: begin
				for (int i = 0; i < N_LINES; i++) begin
					line_fill[i] = 0;
					line_head[i] = 0;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	task automatic send_item(op_t op, logic [4:0] ln, logic [31:0] t);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tdata <= {1'b0, t, ln, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		merge_apply(op, ln, t);
		@(negedge clk);
	endtask

	task automatic add_row(op_t op, logic [4:0] ln, logic [31:0] t);
		stim_row_t s;
		s.op = op; s.line = ln; s.t = t; s.typed = 0; s.res = '0;
		rows.push_back(s);
	endtask

	task automatic add_row_typed(op_t op, word_res_t r);
		stim_row_t s;
		s.op = op; s.line = '0; s.t = '0; s.typed = 1; s.res = r;
		rows.push_back(s);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic load_line_nd(int ln, logic [31:0] base, int n);
		logic [31:0] t;
		t = base;
		for (int k = 0; k < n; k++) begin
			send_item(OP_LOAD, ln[4:0], t);
			t = t + $urandom_range(0, 2);
		end
	endtask

	always @(posedge clk) begin
		word_res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[65:0];
			if (pending_words.size() == 0) begin
				$display("unexpected result item %h at %0t", m_axis_tdata, $realtime);
				fails++;
			end else begin
				want = pending_words.pop_front();
				if (got.word !== want.word) report_mismatch("word", got.word, want.word);
				if (got.word_time !== want.word_time)
					report_mismatch("word_time", got.word_time, want.word_time);
				if (got.done_res !== want.done_res)
					report_mismatch("done_res", got.done_res, want.done_res);
				if (got.overflow !== want.overflow)
					report_mismatch("overflow", got.overflow, want.overflow);
			end
		end
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				wait (!hold_off);
				@(negedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("bit_event_word_merger verification failed");
			$finish;
		end
	end

	initial begin
		word_res_t r;
		int sel, ln, burst, sent;
		for (int i = 0; i < N_LINES; i++) begin
			line_fill[i] = 0;
			line_head[i] = 0;
			line_last[i] = 0;
		end
		ovf_sticky = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		r = '0; r.done_res = 1'b1;
		add_row_typed(OP_REQ, r);
		add_row(OP_LOAD, 5'd0, 32'h0000_0000);
		add_row(OP_LOAD, 5'd31, 32'h0000_0000);
		add_row(OP_LOAD, 5'd5, 32'hFFFF_FFFF);
		add_row(OP_LOAD, 5'd31, 32'hFFFF_FFFF);
		add_row(OP_LOAD, 5'd10, 32'hAAAA_5555);
		add_row(OP_LOAD, 5'd21, 32'h5555_AAAA);
		add_row(OP_NONE, 5'd3, 32'h1234_5678);
		for (int k = 0; k < 6; k++) add_row(OP_REQ, 5'd0, 32'd0);
		add_row(OP_LOAD, 5'd7, 32'd9);
		add_row(OP_CLEAR, 5'd31, 32'hFFFF_FFFF);
		add_row_typed(OP_REQ, r);
		foreach (rows[i]) begin
			send_item(rows[i].op, rows[i].line, rows[i].t);
			if (rows[i].typed) void'(pending_words.pop_back());
			if (rows[i].typed) pending_words.push_back(rows[i].res);
		end
		drain();

		// fill one line past its depth
		for (int k = 0; k < DEPTH + 3; k++) send_item(OP_LOAD, 5'd3, k);
		send_item(OP_REQ, 5'd0, 32'd0);
		send_item(OP_CLEAR, 5'd0, 32'd0);

		// long receiver stall while requests keep coming
		for (int k = 0; k < 4; k++) send_item(OP_LOAD, k, 32'd100);
		hold_off = 1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			begin
				for (int k = 0; k < 8; k++) send_item(OP_REQ, 5'd0, 32'd0);
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		join
		send_item(OP_CLEAR, 5'd0, 32'd0);
		for (int i = 0; i < N_LINES; i++) line_last[i] = 0;

		// random: well-formed bursts of loads then requests, some noise
		sent = 0;
		while (sent < N_RANDOM) begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				burst = $urandom_range(1, 12);
				for (int k = 0; k < burst; k++) begin
					ln = $urandom_range(0, N_LINES - 1);
					if ($urandom_range(0, 9) == 0)
						line_last[ln] = $urandom;
					else
						line_last[ln] = line_last[ln] + $urandom_range(0, 3);
					send_item(OP_LOAD, ln[4:0], line_last[ln]);
				end
				sent += burst;
				burst = $urandom_range(1, 10);
				for (int k = 0; k < burst; k++) send_item(OP_REQ, $urandom, $urandom);
				sent += burst;
			end else if (sel < 88) begin
				send_item(OP_LOAD, $urandom, $urandom);
				sent++;
			end else if (sel < 93) begin
				send_item(OP_CLEAR, $urandom, $urandom);
				for (int i = 0; i < N_LINES; i++) line_last[i] = 0;
				sent++;
			end else if (sel < 96) begin
				send_item(OP_NONE, $urandom, $urandom);
				sent++;
			end else begin
				send_item(OP_REQ, $urandom, $urandom);
				sent++;
			end
		end

		drain();
		if (fails == 0) begin
			$display("bit_event_word_merger verification clean");
		end else begin
			$display("bit_event_word_merger verification failed");
		end
		$finish;
	end
endmodule
